>>> sv/bnf_pkg.sv
// ----------------------------------------------------------------------------
// bnf_pkg
// Shared types, widths and codes of the batch normalisation forward unit.
// ----------------------------------------------------------------------------
package bnf_pkg;

	localparam int CHANNELS   = 64;
	localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int CHAN_FLD_W = 6;
	localparam int KIND_W     = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 21;

	// iterative divider: 57-bit dividend, 32-bit divisor
	localparam int DIV_NUM_W  = 57;
	localparam int DIV_DEN_W  = 32;
	localparam int DIV_CNT_W  = $clog2(DIV_NUM_W);

	// iterative square root: 50-bit radicand, 25-bit root
	localparam int SQRT_IN_W  = 50;
	localparam int SQRT_OUT_W = SQRT_IN_W / 2;
	localparam int SQRT_CNT_W = $clog2(SQRT_OUT_W);

	localparam logic signed [31:0] Q_ONE = 32'sd65536;

	localparam logic [KIND_W-1:0] KIND_LOAD = 3'd0;
	localparam logic [KIND_W-1:0] KIND_SUM  = 3'd1;
	localparam logic [KIND_W-1:0] KIND_MEAN = 3'd2;
	localparam logic [KIND_W-1:0] KIND_SQ   = 3'd3;
	localparam logic [KIND_W-1:0] KIND_VAR  = 3'd4;
	localparam logic [KIND_W-1:0] KIND_NORM = 3'd5;

	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MOMENTUM     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_EPSILON      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TRAIN_MODE   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BYPASS       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE_SHIFT  = 3'd5;

	typedef struct packed {
		logic signed [55:0] sum;
		logic signed [31:0] bmean;
		logic signed [31:0] bvar;
		logic signed [31:0] rmean;
		logic signed [31:0] rvar;
		logic signed [31:0] miu;
		logic signed [31:0] inv;
	} stats_row_t;

	typedef struct packed {
		logic signed [31:0] gamma;
		logic signed [31:0] beta;
	} param_row_t;

	localparam int STATS_W = $bits(stats_row_t);
	localparam int PARAM_W = $bits(param_row_t);

endpackage

>>> sv/bnf_if.sv
// ----------------------------------------------------------------------------
// bnf_if
// Valid/ready channels of the batch normalisation forward unit.
// ----------------------------------------------------------------------------
interface bnf_in_if import bnf_pkg::*; ();
	logic                         valid;
	logic                         ready;
	logic [KIND_W-1:0]            kind;
	logic [CHAN_FLD_W-1:0]        channel;
	logic signed [31:0]           sample;
	logic signed [31:0]           gamma_value;
	logic signed [31:0]           beta_value;

	modport source (output valid, kind, channel, sample, gamma_value, beta_value,
		input ready);
	modport sink (input valid, kind, channel, sample, gamma_value, beta_value,
		output ready);
endinterface

interface bnf_out_if import bnf_pkg::*; ();
	logic                         valid;
	logic                         ready;
	logic [CHAN_FLD_W-1:0]        out_channel;
	logic signed [31:0]           out_value;

	modport source (output valid, out_channel, out_value, input ready);
	modport sink (input valid, out_channel, out_value, output ready);
endinterface

>>> sv/bnf_ram.sv
// ----------------------------------------------------------------------------
// bnf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bnf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(DEPTH)-1:0]         waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic                             re,
	input  logic [$clog2(DEPTH)-1:0]         raddr,
	output logic [WIDTH-1:0]                 rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

>>> sv/bnf_div.sv
// ----------------------------------------------------------------------------
// bnf_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bnf_div import bnf_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [DIV_NUM_W-1:0] num,
	input  logic [DIV_DEN_W-1:0] den,
	output logic                 done,
	output logic [DIV_NUM_W-1:0] quo
);
	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_NUM_W-1:0] quo_q;
	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_DEN_W:0]   rem_t;
	logic [DIV_DEN_W:0]   diff;
	logic                 ge;

	assign rem_t = {rem_q, quo_q[DIV_NUM_W-1]};
	assign diff  = rem_t - {1'b0, den_q};
	assign ge    = rem_t >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_NUM_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIV_NUM_W-2:0], ge};
			rem_q <= ge ? diff[DIV_DEN_W-1:0] : rem_t[DIV_DEN_W-1:0];
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
endmodule

>>> sv/bnf_isqrt.sv
// ----------------------------------------------------------------------------
// bnf_isqrt
// Digit-by-digit integer square root, one root bit per cycle (floor).
// ----------------------------------------------------------------------------
module bnf_isqrt import bnf_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [SQRT_IN_W-1:0]  x,
	output logic                  done,
	output logic [SQRT_OUT_W-1:0] root
);
	logic                  busy_q;
	logic                  done_q;
	logic [SQRT_CNT_W-1:0] cnt_q;
	logic [SQRT_IN_W-1:0]  xs_q;
	logic [SQRT_OUT_W+1:0] rem_q;
	logic [SQRT_OUT_W-1:0] root_q;
	logic [SQRT_OUT_W+3:0] rem_t;
	logic [SQRT_OUT_W+3:0] trial;
	logic [SQRT_OUT_W+3:0] diff;
	logic                  ge;

	assign rem_t = {rem_q, xs_q[SQRT_IN_W-1 -: 2]};
	assign trial = {2'b00, root_q, 2'b01};
	assign diff  = rem_t - trial;
	assign ge    = rem_t >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= SQRT_CNT_W'(SQRT_OUT_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			xs_q   <= x;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			xs_q   <= {xs_q[SQRT_IN_W-3:0], 2'b00};
			rem_q  <= ge ? diff[SQRT_OUT_W+1:0] : rem_t[SQRT_OUT_W+1:0];
			root_q <= {root_q[SQRT_OUT_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;
endmodule

>>> sv/batch_norm_forward_unit.sv
// ----------------------------------------------------------------------------
// batch_norm_forward_unit
// Per-channel batch normalisation forward pass, Q16.16, one shared multiplier,
// divider and square root under a sequencer over a per-channel statistics RAM.
// ----------------------------------------------------------------------------
//   channel   | dir | payload                                      | transfer
//   items     | in  | kind, channel, sample, gamma_value, beta_value | valid & ready
//   results   | out | out_channel, out_value                       | valid & ready
//   cfg_*     | in  | cfg_index, cfg_data                          | cfg_write
//
// Load writes the parameter RAM on acceptance. Sum reads and writes the row;
// square sum adds a multiply and an accumulate; normalise multiplies, rounds
// and, with scale and shift, multiplies and adds beta, plus any wait for the
// result register to drain. Finish mean walks all channels through the divider;
// finish var through the divider, four running-average multiplies in training,
// and a second division and root unless the guarded variance is zero. After
// reset a clearing pass initialises the stats RAM; no input transfer is taken
// meanwhile. The result register lets the core go on while a result waits.
module batch_norm_forward_unit import bnf_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	bnf_in_if.sink                items,
	bnf_out_if.source             results
);
	typedef enum logic [4:0] {
		S_CLEAR, S_IDLE, S_NEXT, S_READ, S_WRITE,
		S_SQ_MUL, S_SQ_ACC,
		S_NM_MUL1, S_NM_XHAT, S_NM_MUL2, S_NM_FIN, S_NM_OUT,
		S_FM_DIV,
		S_FV_DIV, S_FV_B1, S_FV_B2, S_FV_B3, S_FV_B4, S_FV_B5,
		S_FV_VAR, S_FV_DIV2, S_FV_SQRT
	} state_t;

	function automatic logic signed [49:0] rnd16(input logic signed [64:0] p);
		logic [64:0] mag;
		logic [48:0] q;
		mag = p[64] ? 65'(-p) : 65'(p);
		q = 49'((mag + 65'd32768) >> 16);
		rnd16 = p[64] ? -$signed({1'b0, q}) : $signed({1'b0, q});
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [50:0] v);
		if (v > 51'sd2147483647) begin
			sat32 = 32'sh7fffffff;
		end else if (v < -51'sd2147483648) begin
			sat32 = 32'sh80000000;
		end else begin
			sat32 = v[31:0];
		end
	endfunction

	function automatic logic signed [55:0] sat56(input logic signed [56:0] v);
		if (v[56] != v[55]) begin
			sat56 = v[56] ? {1'b1, 55'd0} : {1'b0, {55{1'b1}}};
		end else begin
			sat56 = v[55:0];
		end
	endfunction

	// configuration
	logic [20:0] sample_count_q;
	logic [16:0] momentum_q;
	logic [15:0] epsilon_q;
	logic        train_q;
	logic        bypass_q;
	logic        ssen_q;

	state_t             state_q;
	logic [CH_W-1:0]    ch_q;
	logic               walk_q;
	logic [KIND_W-1:0]  kind_q;
	logic signed [31:0] sample_q;
	logic               neg_q;
	stats_row_t         row_q;
	param_row_t         param_q;
	logic signed [64:0] prod_q;
	logic signed [64:0] p1_q;
	logic signed [31:0] res_q;
	logic               out_valid_q;
	logic [CHAN_FLD_W-1:0] out_channel_q;
	logic signed [31:0] out_value_q;

	logic               accept;
	logic               ch_ok;
	logic [20:0]        cnt;
	logic [16:0]        m_eff;
	logic [16:0]        m_rest;
	logic               use_batch;

	logic [STATS_W-1:0] stats_rdata;
	logic [PARAM_W-1:0] param_rdata;
	stats_row_t         stats_rd;
	stats_row_t         read_row;
	param_row_t         param_rd;
	stats_row_t         clear_row;
	logic               stats_we;
	logic [STATS_W-1:0] stats_wdata;
	logic               ram_re;
	logic               param_we;
	param_row_t         param_wdata;

	logic signed [32:0] mul_a;
	logic signed [32:0] mul_b;
	logic signed [65:0] prod_full;
	logic               mul_en;
	logic signed [32:0] dev;
	logic signed [32:0] dev_mag;

	logic                 div_start;
	logic [DIV_NUM_W-1:0] div_num;
	logic [DIV_DEN_W-1:0] div_den;
	logic                 div_done;
	logic [DIV_NUM_W-1:0] div_quo;
	logic signed [31:0]   div_sat;
	logic signed [56:0]   sum_ext;
	logic [DIV_NUM_W-1:0] sum_mag;
	logic signed [31:0]   var_sel;
	logic [31:0]          v_guard;

	logic                  sqrt_start;
	logic                  sqrt_done;
	logic [SQRT_OUT_W-1:0] sqrt_root;

	assign accept = items.valid && items.ready;
	assign ch_ok  = 32'(items.channel) < CHANNELS;
	assign cnt    = (sample_count_q == '0) ? 21'd1 : sample_count_q;
	assign m_eff  = (momentum_q > 17'd65536) ? 17'd65536 : momentum_q;
	assign m_rest = 17'd65536 - m_eff;
	assign use_batch = train_q || bypass_q;

	assign items.ready         = (state_q == S_IDLE);
	assign results.valid       = out_valid_q;
	assign results.out_channel = out_channel_q;
	assign results.out_value   = out_value_q;

	// memories
	assign stats_rd = stats_row_t'(stats_rdata);
	assign param_rd = param_row_t'(param_rdata);
	assign ram_re   = (state_q == S_NEXT);

	// sum items fold the sample in while the row is captured
	always_comb begin
		read_row = stats_rd;
		if (kind_q == KIND_SUM) begin
			read_row.sum = sat56(57'(stats_rd.sum) + 57'(sample_q));
		end
	end

	always_comb begin
		clear_row       = '0;
		clear_row.rvar  = Q_ONE;
	end

	assign stats_we    = (state_q == S_CLEAR) || (state_q == S_WRITE);
	assign stats_wdata = (state_q == S_CLEAR) ? clear_row : row_q;

	assign param_we          = accept && ch_ok && (items.kind == KIND_LOAD);
	assign param_wdata.gamma = items.gamma_value;
	assign param_wdata.beta  = items.beta_value;

	bnf_ram #(.WIDTH(STATS_W), .DEPTH(CHANNELS)) u_stats_ram (
		.clk   (clk),
		.we    (stats_we),
		.waddr (ch_q),
		.wdata (stats_wdata),
		.re    (ram_re),
		.raddr (ch_q),
		.rdata (stats_rdata)
	);

	bnf_ram #(.WIDTH(PARAM_W), .DEPTH(CHANNELS)) u_param_ram (
		.clk   (clk),
		.we    (param_we),
		.waddr (CH_W'(items.channel)),
		.wdata (param_wdata),
		.re    (ram_re),
		.raddr (ch_q),
		.rdata (param_rdata)
	);

	// shared multiplier
	assign dev     = 33'(sample_q) - 33'(row_q.miu);
	assign dev_mag = dev[32] ? -dev : dev;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_SQ_MUL: begin
				mul_a = dev_mag;
				mul_b = dev_mag;
			end
			S_NM_MUL1: begin
				mul_a = dev;
				mul_b = 33'(row_q.inv);
			end
			S_NM_MUL2: begin
				mul_a = 33'(res_q);
				mul_b = 33'(param_q.gamma);
			end
			S_FV_B1: begin
				mul_a = 33'(row_q.rmean);
				mul_b = $signed({16'd0, m_rest});
			end
			S_FV_B2: begin
				mul_a = 33'(row_q.bmean);
				mul_b = $signed({16'd0, m_eff});
			end
			S_FV_B3: begin
				mul_a = 33'(row_q.rvar);
				mul_b = $signed({16'd0, m_rest});
			end
			S_FV_B4: begin
				mul_a = 33'(row_q.bvar);
				mul_b = $signed({16'd0, m_eff});
			end
			default: begin
			end
		endcase
	end

	assign mul_en    = state_q inside {S_SQ_MUL, S_NM_MUL1, S_NM_MUL2,
		S_FV_B1, S_FV_B2, S_FV_B3, S_FV_B4};
	assign prod_full = mul_a * mul_b;

	// divider operands: rounded sum / count, or 2^48 / guarded variance
	assign sum_ext = 57'(stats_rd.sum);
	assign sum_mag = sum_ext[56] ? 57'(-sum_ext) : 57'(sum_ext);
	assign var_sel = use_batch ? row_q.bvar : row_q.rvar;
	assign v_guard = (var_sel[31] ? 32'd0 : 32'(var_sel)) + 32'(epsilon_q);

	assign div_start = ((state_q == S_READ) && ((kind_q == KIND_MEAN) || (kind_q == KIND_VAR)))
		|| ((state_q == S_FV_VAR) && (v_guard != '0));
	assign div_num = (state_q == S_READ) ? (sum_mag + 57'(cnt >> 1)) : (57'd1 << 48);
	assign div_den = (state_q == S_READ) ? 32'(cnt) : v_guard;

	always_comb begin
		if (!neg_q) begin
			div_sat = (div_quo > 57'd2147483647) ? 32'sh7fffffff : $signed(div_quo[31:0]);
		end else begin
			div_sat = (div_quo > 57'd2147483648) ? 32'sh80000000 : -$signed(div_quo[31:0]);
		end
	end

	bnf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	assign sqrt_start = (state_q == S_FV_DIV2) && div_done;

	bnf_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqrt_start),
		.x      (div_quo[SQRT_IN_W-1:0]),
		.done   (sqrt_done),
		.root   (sqrt_root)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_count_q <= 21'd1;
			momentum_q     <= 17'd6554;
			epsilon_q      <= 16'd1;
			train_q        <= 1'b1;
			bypass_q       <= 1'b0;
			ssen_q         <= 1'b1;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_SAMPLE_COUNT: sample_count_q <= cfg_data;
				REG_MOMENTUM:     momentum_q     <= cfg_data[16:0];
				REG_EPSILON:      epsilon_q      <= cfg_data[15:0];
				REG_TRAIN_MODE:   train_q        <= cfg_data[0];
				REG_BYPASS:       bypass_q       <= cfg_data[0];
				REG_SCALE_SHIFT:  ssen_q         <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// sequencer, control state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			ch_q        <= '0;
			walk_q      <= 1'b0;
			kind_q      <= KIND_LOAD;
			out_valid_q <= 1'b0;
		end else begin
			if (results.ready && (state_q != S_NM_OUT)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					if (ch_q == CH_W'(CHANNELS - 1)) begin
						ch_q    <= '0;
						state_q <= S_IDLE;
					end else begin
						ch_q <= ch_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (accept) begin
						kind_q <= items.kind;
						case (items.kind)
							KIND_MEAN, KIND_VAR: begin
								walk_q  <= 1'b1;
								ch_q    <= '0;
								state_q <= S_NEXT;
							end
							KIND_SUM, KIND_SQ, KIND_NORM: begin
								walk_q <= 1'b0;
								ch_q   <= CH_W'(items.channel);
								if (ch_ok) begin
									state_q <= S_NEXT;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_NEXT: state_q <= S_READ;
				S_READ: begin
					case (kind_q)
						KIND_SUM:  state_q <= S_WRITE;
						KIND_SQ:   state_q <= S_SQ_MUL;
						KIND_NORM: state_q <= S_NM_MUL1;
						KIND_MEAN: state_q <= S_FM_DIV;
						KIND_VAR:  state_q <= S_FV_DIV;
						default:   state_q <= S_IDLE;
					endcase
				end
				S_SQ_MUL:  state_q <= S_SQ_ACC;
				S_SQ_ACC:  state_q <= S_WRITE;
				S_NM_MUL1: state_q <= S_NM_XHAT;
				S_NM_XHAT: state_q <= ssen_q ? S_NM_MUL2 : S_NM_OUT;
				S_NM_MUL2: state_q <= S_NM_FIN;
				S_NM_FIN:  state_q <= S_NM_OUT;
				S_NM_OUT: begin
					if (!out_valid_q || results.ready) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				S_FM_DIV: begin
					if (div_done) begin
						state_q <= S_WRITE;
					end
				end
				S_FV_DIV: begin
					if (div_done) begin
						state_q <= train_q ? S_FV_B1 : S_FV_VAR;
					end
				end
				S_FV_B1: state_q <= S_FV_B2;
				S_FV_B2: state_q <= S_FV_B3;
				S_FV_B3: state_q <= S_FV_B4;
				S_FV_B4: state_q <= S_FV_B5;
				S_FV_B5: state_q <= S_FV_VAR;
				S_FV_VAR: state_q <= (v_guard == '0) ? S_WRITE : S_FV_DIV2;
				S_FV_DIV2: begin
					if (div_done) begin
						state_q <= S_FV_SQRT;
					end
				end
				S_FV_SQRT: begin
					if (sqrt_done) begin
						state_q <= S_WRITE;
					end
				end
				S_WRITE: begin
					if (walk_q && (ch_q != CH_W'(CHANNELS - 1))) begin
						ch_q    <= ch_q + 1'b1;
						state_q <= S_NEXT;
					end else begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (mul_en) begin
			prod_q <= prod_full[64:0];
		end
		case (state_q)
			S_IDLE: begin
				sample_q <= items.sample;
			end
			S_READ: begin
				row_q   <= read_row;
				param_q <= param_rd;
				neg_q   <= stats_rd.sum[55];
			end
			S_SQ_ACC: row_q.sum <= sat56(57'(row_q.sum) + 57'(rnd16(prod_q)));
			S_NM_XHAT: res_q <= sat32(51'(rnd16(prod_q)));
			S_NM_FIN: res_q <= sat32(51'(rnd16(prod_q)) + 51'(param_q.beta));
			S_NM_OUT: begin
				if (!out_valid_q || results.ready) begin
					out_channel_q <= CHAN_FLD_W'(ch_q);
					out_value_q   <= res_q;
				end
			end
			S_FM_DIV: begin
				if (div_done) begin
					row_q.bmean <= div_sat;
					row_q.miu   <= use_batch ? div_sat : row_q.rmean;
					row_q.sum   <= '0;
				end
			end
			S_FV_DIV: begin
				if (div_done) begin
					row_q.bvar <= div_sat;
					row_q.sum  <= '0;
				end
			end
			S_FV_B2: p1_q <= prod_q;
			S_FV_B3: row_q.rmean <= sat32(51'(rnd16(p1_q + prod_q)));
			S_FV_B4: p1_q <= prod_q;
			S_FV_B5: row_q.rvar <= sat32(51'(rnd16(p1_q + prod_q)));
			S_FV_VAR: begin
				if (v_guard == '0) begin
					row_q.inv <= 32'sh7fffffff;
				end
			end
			S_FV_SQRT: begin
				if (sqrt_done) begin
					row_q.inv <= 32'(sqrt_root);
				end
			end
			default: begin
			end
		endcase
	end

`ifndef SYNTH
	a_result_from_norm: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_NM_OUT)
		else $error("result raised outside the normalise output step");

	a_div_done_awaited: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_FM_DIV || state_q == S_FV_DIV || state_q == S_FV_DIV2))
		else $error("divider finished while the sequencer was not waiting");

	a_root_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sqrt_done |-> !(sqrt_root[SQRT_OUT_W-1] && (|sqrt_root[SQRT_OUT_W-2:0])))
		else $error("inverse root above 2^24");
`endif
endmodule

>>> verif/bnf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bnf_checker
// Watches the item, result and register ports of the batch normalisation
// forward unit, predicts every normalised sample and compares each result.
// ----------------------------------------------------------------------------
module bnf_checker import bnf_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	bnf_in_if                     items,
	bnf_out_if                    results,
	output int                    fail_count,
	output int                    pending
);

	localparam longint ACC_MAX = (64'sd1 <<< 55) - 1;
	localparam longint ACC_MIN = -ACC_MAX - 1;

	typedef struct {
		logic [CHAN_FLD_W-1:0] ch;
		logic signed [31:0]    value;
	} norm_result_t;

	norm_result_t norm_expect_q[$];

	logic [20:0] n_samples;
	logic [16:0] mom;
	logic [15:0] eps;
	logic        train, bypass, scale_on;

	longint acc [CHANNELS];
	int     bmean [CHANNELS], bvar [CHANNELS], rmean [CHANNELS], rvar [CHANNELS];
	int     mean_sel [CHANNELS], inv_sd [CHANNELS], gam [CHANNELS], bet [CHANNELS];

	assign pending = norm_expect_q.size();

	function automatic int clamp32(longint v);
		if (v > 64'sd2147483647) return 32'h7FFFFFFF;
		if (v < -64'sd2147483648) return 32'h80000000;
		return int'(v);
	endfunction

	function automatic longint clamp_acc(longint v);
		if (v > ACC_MAX) return ACC_MAX;
		if (v < ACC_MIN) return ACC_MIN;
		return v;
	endfunction

	// round to nearest, halves away from zero
	function automatic longint round_div(longint num, longint unsigned den);
		logic neg;
		longint unsigned mag, q;
		neg = num < 0;
		mag = neg ? -num : num;
		q = (mag + den / 2) / den;
		return neg ? -longint'(q) : longint'(q);
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned x);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic longint unsigned divisor();
		return (n_samples == 0) ? 1 : n_samples;
	endfunction

	function automatic int running_blend(int old, int fresh);
		longint m;
		m = (mom > 17'd65536) ? 65536 : longint'(mom);
		return clamp32(round_div(longint'(old) * (65536 - m) + longint'(fresh) * m, 65536));
	endfunction

	task automatic close_mean();
		for (int c = 0; c < CHANNELS; c++) begin
			bmean[c] = clamp32(round_div(acc[c], divisor()));
			mean_sel[c] = (train || bypass) ? bmean[c] : rmean[c];
			acc[c] = 0;
		end
	endtask

	task automatic close_var();
		int var_sel;
		longint unsigned v, y;
		for (int c = 0; c < CHANNELS; c++) begin
			bvar[c] = clamp32(round_div(acc[c], divisor()));
			if (train) begin
				rmean[c] = running_blend(rmean[c], bmean[c]);
				rvar[c] = running_blend(rvar[c], bvar[c]);
			end
			var_sel = (train || bypass) ? bvar[c] : rvar[c];
			v = (var_sel < 0 ? 0 : longint'(var_sel)) + eps;
			if (v == 0) begin
				y = 64'h7FFFFFFF;
			end else begin
				y = int_sqrt((64'd1 << 48) / v);
				if (y > 64'h7FFFFFFF) y = 64'h7FFFFFFF;
			end
			inv_sd[c] = int'(y);
			acc[c] = 0;
		end
	endtask

	task automatic report_mismatch(string msg);
		$display("[%0t] MISMATCH: %s", $realtime, msg);
		fail_count++;
	endtask

	task automatic predict_item();
		int ch;
		longint s, dev;
		longint unsigned mag, sq;
		int xhat;
		norm_result_t r;
		ch = items.channel;
		s = longint'(items.sample);
		case (items.kind)
			KIND_MEAN: close_mean();
			KIND_VAR:  close_var();
			KIND_LOAD: begin
				gam[ch] = items.gamma_value;
				bet[ch] = items.beta_value;
			end
			KIND_SUM: acc[ch] = clamp_acc(acc[ch] + s);
			KIND_SQ: begin
				dev = s - longint'(mean_sel[ch]);
				mag = dev < 0 ? -dev : dev;
				sq = (mag * mag + 32768) >> 16;
				acc[ch] = clamp_acc(acc[ch] + longint'(sq));
			end
			KIND_NORM: begin
				dev = s - longint'(mean_sel[ch]);
				xhat = clamp32(round_div(dev * longint'(inv_sd[ch]), 65536));
				r.ch = ch;
				if (scale_on)
					r.value = clamp32(round_div(longint'(xhat) * longint'(gam[ch]), 65536)
						+ longint'(bet[ch]));
				else
					r.value = xhat;
				norm_expect_q.push_back(r);
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_samples = 1; mom = 6554; eps = 1;
			train = 1; bypass = 0; scale_on = 1;
			for (int c = 0; c < CHANNELS; c++) begin
				acc[c] = 0; bmean[c] = 0; bvar[c] = 0; rmean[c] = 0;
				rvar[c] = 65536; mean_sel[c] = 0; inv_sd[c] = 0;
				gam[c] = 0; bet[c] = 0;
			end
			norm_expect_q.delete();
		end else begin
			// result first: it belongs to an item taken at an earlier edge
			if (results.valid && results.ready) begin
				if (norm_expect_q.size() == 0) begin
					report_mismatch($sformatf("unexpected result ch %0d value %h",
						results.out_channel, results.out_value));
				end else begin
					norm_result_t e;
					e = norm_expect_q.pop_front();
					if (results.out_channel !== e.ch)
						report_mismatch($sformatf("out_channel %0d, expected %0d",
							results.out_channel, e.ch));
					if (results.out_value !== e.value)
						report_mismatch($sformatf("out_value %h, expected %h (ch %0d)",
							results.out_value, e.value, e.ch));
				end
			end
			if (items.valid && items.ready)
				predict_item();
			if (cfg_write) begin
				case (cfg_index)
					REG_SAMPLE_COUNT: n_samples = cfg_data[20:0];
					REG_MOMENTUM:     mom = cfg_data[16:0];
					REG_EPSILON:      eps = cfg_data[15:0];
					REG_TRAIN_MODE:   train = cfg_data[0];
					REG_BYPASS:       bypass = cfg_data[0];
					REG_SCALE_SHIFT:  scale_on = cfg_data[0];
					default: ;
				endcase
			end
		end
	end

	initial fail_count = 0;

endmodule

>>> verif/batch_norm_forward_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// batch_norm_forward_unit_tb
// Streams whole batches (load, sum, mean, square sum, variance, normalise)
// with random content, noise items and random stalls on both sides, under
// several register settings; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module batch_norm_forward_unit_tb;
	import bnf_pkg::*;

	// settle time for finish var, which walks every channel
	localparam int SETTLE = 11000;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_write;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    fail_count, pending;
	int                    item_total;
	bit                    burst, hold_req, hold_done, scale_en;
	bit                    loaded [CHANNELS];

	bnf_in_if  item_ch ();
	bnf_out_if result_ch ();

	batch_norm_forward_unit dut (
		.clk(clk), .arst_n(arst_n), .cfg_write(cfg_write), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .items(item_ch), .results(result_ch)
	);

	bnf_checker u_checker (
		.clk(clk), .arst_n(arst_n), .cfg_write(cfg_write), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .items(item_ch), .results(result_ch),
		.fail_count(fail_count), .pending(pending)
	);

	initial clk = 0;
	always #5 clk = ~clk;

	initial begin
		#50ms;
		$display("Test completed with failures");
		$finish;
	end

	// result side: random back-pressure, one long hold-off on request
	initial begin
		int n;
		result_ch.ready = 0;
		@(posedge arst_n);
		forever begin
			n = burst ? 0 : $urandom_range(0, 4);
			if (hold_req && !hold_done) begin
				n = 400;
				hold_done = 1;
			end
			if (n > 0) begin
				result_ch.ready <= 0;
				repeat (n) @(posedge clk);
			end
			result_ch.ready <= 1;
			@(posedge clk);
			while (!(result_ch.valid && result_ch.ready)) @(posedge clk);
		end
	end

	task automatic send(logic [KIND_W-1:0] k, logic [5:0] ch, logic [31:0] s,
		logic [31:0] g, logic [31:0] b);
		int n;
		// scaling an unloaded channel is outside the contract: load it instead
		if (k == KIND_NORM && scale_en && !loaded[ch]) k = KIND_LOAD;
		if (k == KIND_LOAD) loaded[ch] = 1;
		n = burst ? 0 : $urandom_range(0, 4);
		if (n > 0) begin
			item_ch.valid <= 0;
			repeat (n) @(posedge clk);
		end
		item_ch.valid <= 1;
		item_ch.kind <= k;
		item_ch.channel <= ch;
		item_ch.sample <= s;
		item_ch.gamma_value <= g;
		item_ch.beta_value <= b;
		@(posedge clk);
		while (!(item_ch.valid && item_ch.ready)) @(posedge clk);
		item_total++;
	endtask

	function automatic logic [31:0] pick_sample();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return $urandom_range(0, 1 << 20) - (1 << 19);
			2: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
			default: return $urandom_range(0, 1) ? ($urandom >> 8) : -($urandom >> 8);
		endcase
	endfunction

	function automatic logic [31:0] pick_gain();
		if ($urandom_range(0, 1)) return $urandom;
		return 32'h10000 + $urandom_range(0, 1 << 17) - (1 << 16);
	endfunction

	// leaves the write enable high; the caller drops it after the last write
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
		cfg_write <= 1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		if (idx == REG_SCALE_SHIFT) scale_en = d[0];
	endtask

	task automatic wait_idle();
		item_ch.valid <= 0;
		while (pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic noise();
		logic [2:0] k;
		k = 3'($urandom_range(0, 7));
		if (k == KIND_MEAN || k == KIND_VAR) k = KIND_SUM;
		send(k, 6'($urandom), pick_sample(), $urandom, $urandom);
	endtask

	task automatic new_setting();
		logic [20:0] cnt;
		logic [16:0] m;
		logic [15:0] e;
		case ($urandom_range(0, 5))
			0: cnt = 0;
			1: cnt = 21'd1048576;
			2: cnt = 21'h1FFFFF;
			default: cnt = 21'($urandom_range(1, 6));
		endcase
		case ($urandom_range(0, 4))
			0: m = 0;
			1: m = 17'd65536;
			2: m = 17'h1FFFF;
			default: m = 17'($urandom_range(0, 65536));
		endcase
		case ($urandom_range(0, 3))
			0: e = 0;
			1: e = 16'hFFFF;
			default: e = 16'($urandom_range(0, 300));
		endcase
		write_reg(REG_SAMPLE_COUNT, cnt);
		write_reg(REG_MOMENTUM, CFG_DATA_W'(m));
		write_reg(REG_EPSILON, CFG_DATA_W'(e));
		write_reg(REG_TRAIN_MODE, CFG_DATA_W'($urandom_range(0, 1)));
		write_reg(REG_BYPASS, CFG_DATA_W'($urandom_range(0, 1)));
		write_reg(REG_SCALE_SHIFT, CFG_DATA_W'($urandom_range(0, 1)));
		cfg_write <= 0;
	endtask

	task automatic run_batch();
		int per_ch, nch;
		logic [5:0] chs [4];
		per_ch = $urandom_range(1, 4);
		nch = $urandom_range(1, 4);
		for (int i = 0; i < nch; i++) begin
			chs[i] = 6'($urandom);
			send(KIND_LOAD, chs[i], $urandom, pick_gain(), $urandom);
		end
		for (int i = 0; i < nch; i++)
			for (int j = 0; j < per_ch; j++) begin
				send(KIND_SUM, chs[i], pick_sample(), $urandom, $urandom);
				if ($urandom_range(0, 11) == 0) noise();
			end
		send(KIND_MEAN, 6'($urandom), $urandom, $urandom, $urandom);
		for (int i = 0; i < nch; i++)
			for (int j = 0; j < per_ch; j++) begin
				send(KIND_SQ, chs[i], pick_sample(), $urandom, $urandom);
				if ($urandom_range(0, 11) == 0) noise();
			end
		send(KIND_VAR, 6'($urandom), $urandom, $urandom, $urandom);
		for (int i = 0; i < 25; i++) begin
			if ($urandom_range(0, 11) == 0) noise();
			else send(KIND_NORM, chs[$urandom_range(0, nch - 1)], pick_sample(),
				$urandom, $urandom);
		end
	endtask

	initial begin
		int batch;
		arst_n = 0;
		cfg_write = 0;
		cfg_index = 0;
		cfg_data = 0;
		item_ch.valid = 0;
		item_ch.kind = KIND_LOAD;
		item_ch.channel = 0;
		item_ch.sample = 0;
		item_ch.gamma_value = 0;
		item_ch.beta_value = 0;
		burst = 0; hold_req = 0; hold_done = 0; scale_en = 1;
		item_total = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: field extremes, every kind, unknown kinds
		send(KIND_LOAD, 0, 0, 32'h7FFFFFFF, 32'h80000000);
		send(KIND_LOAD, 63, 0, 32'h80000000, 32'h7FFFFFFF);
		send(KIND_SUM, 0, 32'h7FFFFFFF, 0, 0);
		send(KIND_SUM, 63, 32'h80000000, 0, 0);
		send(KIND_MEAN, 0, 0, 0, 0);
		send(KIND_SQ, 0, 32'h80000000, 0, 0);
		send(KIND_SQ, 63, 32'h7FFFFFFF, 0, 0);
		send(KIND_VAR, 0, 0, 0, 0);
		send(KIND_NORM, 0, 32'h7FFFFFFF, 0, 0);
		send(KIND_NORM, 0, 32'h80000000, 0, 0);
		send(KIND_NORM, 63, 32'h80000000, 0, 0);
		send(KIND_NORM, 63, 0, 0, 0);
		send(3'd6, 5, 32'h12345678, 0, 0);
		send(3'd7, 63, 32'h87654321, 0, 0);

		// zero variance with zero epsilon: inverse root pins at full scale
		wait_idle();
		write_reg(REG_EPSILON, 0);
		write_reg(REG_SAMPLE_COUNT, 1);
		cfg_write <= 0;
		send(KIND_LOAD, 5, 0, 32'h00010000, 0);
		send(KIND_SUM, 5, 32'h00030000, 0, 0);
		send(KIND_MEAN, 0, 0, 0, 0);
		send(KIND_SQ, 5, 32'h00030000, 0, 0);
		send(KIND_VAR, 0, 0, 0, 0);
		send(KIND_NORM, 5, 32'h00030001, 0, 0);
		send(KIND_NORM, 5, 32'h00020000, 0, 0);

		batch = 0;
		while (item_total < 2000) begin
			if (batch % 4 == 0) begin
				wait_idle();
				new_setting();
			end
			burst = ($urandom_range(0, 3) == 0);
			if (batch == 3) hold_req = 1;
			run_batch();
			batch++;
		end
		item_ch.valid <= 0;
		burst = 0;
		while (pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

>>> sim.f
sv/bnf_pkg.sv
sv/bnf_if.sv
sv/bnf_ram.sv
sv/bnf_div.sv
sv/bnf_isqrt.sv
sv/batch_norm_forward_unit.sv
verif/bnf_checker.sv
verif/batch_norm_forward_unit_tb.sv
